>>> design/hba_pkg.sv
// ----------------------------------------------------------------------------
// hba_pkg
// Shared sizes, codes and controller/datapath types of the block allocator.
// ----------------------------------------------------------------------------
package hba_pkg;

    // table and field sizes
    localparam int TABLE_ENTRIES = 128;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int ADDR_W        = 39;
    localparam int LEN_W         = 33;
    localparam int REQ_W         = 32;
    localparam int PAGES_W       = 21;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_W       = ADDR_W + LEN_W;
    localparam int PAGE_BYTES    = 4096;
    localparam int ALIGN_BYTES   = 16;

    // stream and configuration port widths
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 39;

    // configuration reset values
    localparam logic [ADDR_W-1:0]  HEAP_BASE_RST = ADDR_W'(4096);
    localparam logic [PAGES_W-1:0] MAX_PAGES_RST = PAGES_W'(1024);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAGES = 1'b1;

    // request kinds
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd3;

    // datapath commands
    typedef logic [4:0] cmd_t;
    localparam cmd_t C_NOP         = 5'd0;
    localparam cmd_t C_LOAD        = 5'd1;
    localparam cmd_t C_START       = 5'd2;
    localparam cmd_t C_SCAN_INIT   = 5'd3;
    localparam cmd_t C_I_INC       = 5'd4;
    localparam cmd_t C_J_ZERO      = 5'd5;
    localparam cmd_t C_J_INC       = 5'd6;
    localparam cmd_t C_RD_I        = 5'd7;
    localparam cmd_t C_RD_J        = 5'd8;
    localparam cmd_t C_A_LOAD      = 5'd9;
    localparam cmd_t C_MERGE_AJ    = 5'd10;
    localparam cmd_t C_MERGE_JA    = 5'd11;
    localparam cmd_t C_FREE_MARK   = 5'd12;
    localparam cmd_t C_BEST_TAKE   = 5'd13;
    localparam cmd_t C_TOP_TAKE    = 5'd14;
    localparam cmd_t C_GROW        = 5'd15;
    localparam cmd_t C_NEW_PAGE    = 5'd16;
    localparam cmd_t C_EXTEND      = 5'd17;
    localparam cmd_t C_SET_STARTED = 5'd18;
    localparam cmd_t C_TB_BEST     = 5'd19;
    localparam cmd_t C_SPLIT_TAIL  = 5'd20;
    localparam cmd_t C_SPLIT_HEAD  = 5'd21;
    localparam cmd_t C_GRANT       = 5'd22;
    localparam cmd_t C_ST_ZERO     = 5'd23;
    localparam cmd_t C_ST_NO_ROOM  = 5'd24;
    localparam cmd_t C_ST_BAD_FREE = 5'd25;
    localparam cmd_t C_OUT         = 5'd26;

    // datapath status seen by the controller
    typedef struct packed {
        logic op_free;
        logic addr_zero;
        logic n_zero;
        logic started;
        logic i_last;
        logic j_last;
        logic valid_i;
        logic free_i;
        logic valid_j;
        logic free_j_other;
        logic hit_addr;
        logic avail_i;
        logic sum_ok;
        logic a_to_j;
        logic j_to_a;
        logic fit_better;
        logic best_found;
        logic top_hit;
        logic grow_ok;
        logic top_found;
        logic tb_fits;
        logic split_needed;
        logic out_busy;
    } dp_status_t;

endpackage

>>> design/hba_ram.sv
// ----------------------------------------------------------------------------
// hba_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module hba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/hba_ctrl.sv
// ----------------------------------------------------------------------------
// hba_ctrl
// Sequencer for free lookup, merge passes, first-fit search, growth and split.
// ----------------------------------------------------------------------------
module hba_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  hba_pkg::dp_status_t st,
    output hba_pkg::cmd_t       cmd
);
    import hba_pkg::*;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DEC     = 5'd1;
    localparam logic [4:0] S_F_R     = 5'd2;
    localparam logic [4:0] S_F_E     = 5'd3;
    localparam logic [4:0] S_MSTART  = 5'd4;
    localparam logic [4:0] S_M_I     = 5'd5;
    localparam logic [4:0] S_M_A     = 5'd6;
    localparam logic [4:0] S_M_JR    = 5'd7;
    localparam logic [4:0] S_M_JE    = 5'd8;
    localparam logic [4:0] S_M_DONE  = 5'd9;
    localparam logic [4:0] S_L_R     = 5'd10;
    localparam logic [4:0] S_L_E     = 5'd11;
    localparam logic [4:0] S_L_N     = 5'd12;
    localparam logic [4:0] S_L_DONE  = 5'd13;
    localparam logic [4:0] S_T_R     = 5'd14;
    localparam logic [4:0] S_T_E     = 5'd15;
    localparam logic [4:0] S_G_CHK   = 5'd16;
    localparam logic [4:0] S_SLOT    = 5'd17;
    localparam logic [4:0] S_STARTED = 5'd18;
    localparam logic [4:0] S_G_FIT   = 5'd19;
    localparam logic [4:0] S_SP_CHK  = 5'd20;
    localparam logic [4:0] S_SP_HEAD = 5'd21;
    localparam logic [4:0] S_GRANT   = 5'd22;
    localparam logic [4:0] S_FIN     = 5'd23;

    // what the slot search is for
    localparam logic [1:0] RET_START = 2'd0;
    localparam logic [1:0] RET_LOOP  = 2'd1;
    localparam logic [1:0] RET_SPLIT = 2'd2;

    logic [4:0] state_reg, state_next;
    logic [1:0] ret_reg, ret_next;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= RET_START;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // next state and command
    always_comb
    begin
        cmd        = C_NOP;
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = C_LOAD;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (st.op_free)
                begin
                    if (st.addr_zero)
                    begin
                        cmd        = C_ST_BAD_FREE;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cmd        = C_SCAN_INIT;
                        state_next = S_F_R;
                    end
                end
                else if (st.n_zero)
                begin
                    cmd        = C_ST_ZERO;
                    state_next = S_FIN;
                end
                else if (!st.started)
                begin
                    cmd        = C_START;
                    ret_next   = RET_START;
                    state_next = S_G_CHK;
                end
                else
                begin
                    state_next = S_MSTART;
                end
            end
            // exact-start lookup for free
            S_F_R:
            begin
                if (st.valid_i)
                begin
                    cmd        = C_RD_I;
                    state_next = S_F_E;
                end
                else if (st.i_last)
                begin
                    cmd        = C_ST_BAD_FREE;
                    state_next = S_MSTART;
                end
                else
                begin
                    cmd = C_I_INC;
                end
            end
            S_F_E:
            begin
                if (st.hit_addr)
                begin
                    if (st.avail_i)
                    begin
                        cmd        = C_ST_BAD_FREE;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cmd        = C_FREE_MARK;
                        state_next = S_MSTART;
                    end
                end
                else if (st.i_last)
                begin
                    cmd        = C_ST_BAD_FREE;
                    state_next = S_MSTART;
                end
                else
                begin
                    cmd        = C_I_INC;
                    state_next = S_F_R;
                end
            end
            // pairwise merge, restarting after every merge
            S_MSTART:
            begin
                cmd        = C_SCAN_INIT;
                state_next = S_M_I;
            end
            S_M_I:
            begin
                if (st.free_i)
                begin
                    cmd        = C_RD_I;
                    state_next = S_M_A;
                end
                else if (st.i_last)
                begin
                    state_next = S_M_DONE;
                end
                else
                begin
                    cmd = C_I_INC;
                end
            end
            S_M_A:
            begin
                cmd        = C_A_LOAD;
                state_next = S_M_JR;
            end
            S_M_JR, S_M_JE:
            begin
                if (state_reg == S_M_JR && st.free_j_other)
                begin
                    cmd        = C_RD_J;
                    state_next = S_M_JE;
                end
                else if (state_reg == S_M_JE && st.sum_ok && st.a_to_j)
                begin
                    cmd        = C_MERGE_AJ;
                    state_next = S_M_I;
                end
                else if (state_reg == S_M_JE && st.sum_ok && st.j_to_a)
                begin
                    cmd        = C_MERGE_JA;
                    state_next = S_M_I;
                end
                else if (!st.j_last)
                begin
                    cmd        = C_J_INC;
                    state_next = S_M_JR;
                end
                else if (!st.i_last)
                begin
                    cmd        = C_I_INC;
                    state_next = S_M_I;
                end
                else
                begin
                    state_next = S_M_DONE;
                end
            end
            S_M_DONE:
            begin
                if (st.op_free)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd        = C_SCAN_INIT;
                    state_next = S_L_R;
                end
            end
            // lowest-addressed fitting free block
            S_L_R:
            begin
                if (st.free_i)
                begin
                    cmd        = C_RD_I;
                    state_next = S_L_E;
                end
                else if (st.i_last)
                begin
                    state_next = S_L_DONE;
                end
                else
                begin
                    cmd = C_I_INC;
                end
            end
            S_L_E:
            begin
                if (st.fit_better)
                begin
                    cmd = C_BEST_TAKE;
                end
                state_next = S_L_N;
            end
            S_L_N:
            begin
                if (st.i_last)
                begin
                    state_next = S_L_DONE;
                end
                else
                begin
                    cmd        = C_I_INC;
                    state_next = S_L_R;
                end
            end
            S_L_DONE:
            begin
                if (st.best_found)
                begin
                    state_next = S_SP_CHK;
                end
                else
                begin
                    cmd        = C_SCAN_INIT;
                    state_next = S_T_R;
                end
            end
            // free block ending at the heap top
            S_T_R:
            begin
                if (st.free_i)
                begin
                    cmd        = C_RD_I;
                    state_next = S_T_E;
                end
                else if (st.i_last)
                begin
                    ret_next   = RET_LOOP;
                    state_next = S_G_CHK;
                end
                else
                begin
                    cmd = C_I_INC;
                end
            end
            S_T_E:
            begin
                if (st.top_hit)
                begin
                    cmd        = C_TOP_TAKE;
                    ret_next   = RET_LOOP;
                    state_next = S_G_CHK;
                end
                else if (st.i_last)
                begin
                    ret_next   = RET_LOOP;
                    state_next = S_G_CHK;
                end
                else
                begin
                    cmd        = C_I_INC;
                    state_next = S_T_R;
                end
            end
            // one page of growth
            S_G_CHK:
            begin
                if (st.grow_ok)
                begin
                    cmd        = C_GROW;
                    state_next = S_SLOT;
                end
                else
                begin
                    cmd        = C_ST_NO_ROOM;
                    state_next = S_FIN;
                end
            end
            // first empty descriptor
            S_SLOT:
            begin
                if (!st.valid_j)
                begin
                    case (ret_reg)
                        RET_START:
                        begin
                            cmd        = C_NEW_PAGE;
                            state_next = S_STARTED;
                        end
                        RET_LOOP:
                        begin
                            cmd        = st.top_found ? C_EXTEND : C_NEW_PAGE;
                            state_next = S_G_FIT;
                        end
                        default:
                        begin
                            cmd        = C_SPLIT_TAIL;
                            state_next = S_SP_HEAD;
                        end
                    endcase
                end
                else if (st.j_last)
                begin
                    if (ret_reg == RET_SPLIT)
                    begin
                        state_next = S_GRANT;
                    end
                    else
                    begin
                        cmd        = C_ST_NO_ROOM;
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    cmd = C_J_INC;
                end
            end
            S_STARTED:
            begin
                cmd        = C_SET_STARTED;
                state_next = S_MSTART;
            end
            S_G_FIT:
            begin
                if (st.tb_fits)
                begin
                    cmd        = C_TB_BEST;
                    state_next = S_SP_CHK;
                end
                else
                begin
                    state_next = S_G_CHK;
                end
            end
            // tail split
            S_SP_CHK:
            begin
                if (st.split_needed)
                begin
                    cmd        = C_J_ZERO;
                    ret_next   = RET_SPLIT;
                    state_next = S_SLOT;
                end
                else
                begin
                    state_next = S_GRANT;
                end
            end
            S_SP_HEAD:
            begin
                cmd        = C_SPLIT_HEAD;
                state_next = S_GRANT;
            end
            S_GRANT:
            begin
                cmd        = C_GRANT;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!st.out_busy)
                begin
                    cmd        = C_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // a new word is only taken from idle, and every word ends in idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == C_LOAD) |=> (state_reg == S_DEC))
        else $error("load not followed by decode");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == C_OUT) |-> (state_reg == S_FIN && !st.out_busy))
        else $error("result issued while output busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SLOT && ret_reg == RET_START) |-> !st.started)
        else $error("heap start slot search on started heap");

endmodule

>>> design/hba_dp.sv
// ----------------------------------------------------------------------------
// hba_dp
// Descriptor table, heap registers, scan counters and result register.
// ----------------------------------------------------------------------------
module hba_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  hba_pkg::cmd_t                     cmd,
    output hba_pkg::dp_status_t               st,
    input  logic                              cfg_we,
    input  logic [hba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hba_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_user,
    input  logic [hba_pkg::IN_DATA_W-1:0]     in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [hba_pkg::OUT_DATA_W-1:0]    out_data
);
    import hba_pkg::*;

    localparam logic [LEN_W-1:0] PAGE_LEN   = LEN_W'(PAGE_BYTES);
    localparam logic [LEN_W-1:0] ALIGN_MASK = LEN_W'(ALIGN_BYTES - 1);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(TABLE_ENTRIES - 1);

    // configuration
    logic [ADDR_W-1:0]  base_reg;
    logic [PAGES_W-1:0] max_pages_reg;

    // request
    logic               op_reg;
    logic               n_zero_reg;
    logic [LEN_W-1:0]   need_reg;
    logic [ADDR_W-1:0]  addr_reg;

    // heap state
    logic [ADDR_W-1:0]         heap_top_reg;
    logic [PAGES_W-1:0]        pages_reg;
    logic                      started_reg;
    logic [TABLE_ENTRIES-1:0]  valid_reg;
    logic [TABLE_ENTRIES-1:0]  avail_reg;

    // scan and work registers
    logic [IDX_W-1:0]   i_reg, j_reg;
    logic [ADDR_W-1:0]  a_start_reg;
    logic [LEN_W-1:0]   a_len_reg;
    logic               best_found_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [ADDR_W-1:0]  best_start_reg;
    logic [LEN_W-1:0]   best_len_reg;
    logic               top_found_reg;
    logic [IDX_W-1:0]   top_idx_reg;
    logic [ADDR_W-1:0]  tb_start_reg;
    logic [LEN_W-1:0]   tb_len_reg;
    logic [ADDR_W-1:0]  old_top_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [ADDR_W-1:0]  res_addr_reg;

    // output word
    logic               m_valid_reg;
    logic [ADDR_W-1:0]  m_addr_reg;
    logic [STATUS_W-1:0] m_status_reg;

    // table memory
    logic               we;
    logic [IDX_W-1:0]   waddr, raddr;
    logic [ENTRY_W-1:0] wdata, rdata;
    logic [ADDR_W-1:0]  rd_start;
    logic [LEN_W-1:0]   rd_len;

    // arithmetic
    logic [LEN_W-1:0]   need_in;
    logic [LEN_W:0]     pair_sum;
    logic [ADDR_W:0]    a_end, rd_end, tb_end, top_step, tail_sum;
    logic [LEN_W-1:0]   tb_len_ext;
    logic [LEN_W:0]     need_align;

    hba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_start = rdata[ENTRY_W-1:LEN_W];
    assign rd_len   = rdata[LEN_W-1:0];

    assign need_in    = ({1'b0, in_data[REQ_W-1:0]} + ALIGN_MASK) & ~ALIGN_MASK;
    assign pair_sum   = {1'b0, a_len_reg} + {1'b0, rd_len};
    assign a_end      = {1'b0, a_start_reg} + (ADDR_W + 1)'(a_len_reg);
    assign rd_end     = {1'b0, rd_start} + (ADDR_W + 1)'(rd_len);
    assign tb_end     = {1'b0, tb_start_reg} + (ADDR_W + 1)'(tb_len_reg);
    assign top_step   = {1'b0, heap_top_reg} + (ADDR_W + 1)'(PAGE_BYTES);
    assign tail_sum   = {1'b0, best_start_reg} + (ADDR_W + 1)'(need_reg);
    assign tb_len_ext = tb_len_reg + PAGE_LEN;
    assign need_align = {1'b0, need_reg} + (LEN_W + 1)'(ALIGN_BYTES);

    // status toward the controller
    always_comb
    begin
        st.op_free      = (op_reg == OP_FREE);
        st.addr_zero    = (addr_reg == '0);
        st.n_zero       = n_zero_reg;
        st.started      = started_reg;
        st.i_last       = (i_reg == LAST_IDX);
        st.j_last       = (j_reg == LAST_IDX);
        st.valid_i      = valid_reg[i_reg];
        st.free_i       = valid_reg[i_reg] && avail_reg[i_reg];
        st.valid_j      = valid_reg[j_reg];
        st.free_j_other = valid_reg[j_reg] && avail_reg[j_reg] && (j_reg != i_reg);
        st.hit_addr     = (rd_start == addr_reg);
        st.avail_i      = avail_reg[i_reg];
        st.sum_ok       = !pair_sum[LEN_W];
        st.a_to_j       = (a_end == {1'b0, rd_start});
        st.j_to_a       = (rd_end == {1'b0, a_start_reg});
        st.fit_better   = (rd_len >= need_reg)
                          && (!best_found_reg || rd_start < best_start_reg);
        st.best_found   = best_found_reg;
        st.top_hit      = (rd_end == {1'b0, heap_top_reg});
        st.grow_ok      = (pages_reg < max_pages_reg) && !top_step[ADDR_W];
        st.top_found    = top_found_reg;
        st.tb_fits      = (tb_len_reg >= need_reg);
        st.split_needed = ({1'b0, best_len_reg} > need_align);
        st.out_busy     = m_valid_reg && !out_ready;
    end

    // table write and read ports
    always_comb
    begin
        we    = 1'b0;
        waddr = i_reg;
        wdata = {a_start_reg, pair_sum[LEN_W-1:0]};
        raddr = (cmd == C_RD_J) ? j_reg : i_reg;
        case (cmd)
            C_MERGE_AJ:
            begin
                we = 1'b1;
            end
            C_MERGE_JA:
            begin
                we    = 1'b1;
                waddr = j_reg;
                wdata = {rd_start, pair_sum[LEN_W-1:0]};
            end
            C_NEW_PAGE:
            begin
                we    = 1'b1;
                waddr = j_reg;
                wdata = {old_top_reg, PAGE_LEN};
            end
            C_EXTEND:
            begin
                we    = 1'b1;
                waddr = top_idx_reg;
                wdata = {tb_start_reg, tb_len_ext};
            end
            C_SPLIT_TAIL:
            begin
                we    = 1'b1;
                waddr = j_reg;
                wdata = {tail_sum[ADDR_W-1:0], best_len_reg - need_reg};
            end
            C_SPLIT_HEAD:
            begin
                we    = 1'b1;
                waddr = best_idx_reg;
                wdata = {best_start_reg, need_reg};
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg       <= HEAP_BASE_RST;
            max_pages_reg  <= MAX_PAGES_RST;
            heap_top_reg   <= '0;
            pages_reg      <= '0;
            started_reg    <= 1'b0;
            valid_reg      <= '0;
            avail_reg      <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            best_found_reg <= 1'b0;
            top_found_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HEAP_BASE: base_reg      <= cfg_data[ADDR_W-1:0];
                    CFG_MAX_PAGES: max_pages_reg <= cfg_data[PAGES_W-1:0];
                    default:       base_reg      <= base_reg;
                endcase
            end
            if (cmd == C_OUT)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                m_valid_reg <= 1'b0;
            end
            case (cmd)
                C_START:
                begin
                    valid_reg    <= '0;
                    avail_reg    <= '0;
                    heap_top_reg <= (heap_top_reg < base_reg) ? base_reg : heap_top_reg;
                end
                C_SCAN_INIT:
                begin
                    i_reg          <= '0;
                    best_found_reg <= 1'b0;
                    top_found_reg  <= 1'b0;
                end
                C_I_INC:  i_reg <= i_reg + 1'b1;
                C_J_ZERO: j_reg <= '0;
                C_J_INC:  j_reg <= j_reg + 1'b1;
                C_A_LOAD: j_reg <= '0;
                C_MERGE_AJ:
                begin
                    valid_reg[j_reg] <= 1'b0;
                    i_reg            <= '0;
                end
                C_MERGE_JA:
                begin
                    valid_reg[i_reg] <= 1'b0;
                    i_reg            <= '0;
                end
                C_FREE_MARK: avail_reg[i_reg] <= 1'b1;
                C_BEST_TAKE: best_found_reg   <= 1'b1;
                C_TOP_TAKE:  top_found_reg    <= 1'b1;
                C_GROW:
                begin
                    heap_top_reg <= top_step[ADDR_W-1:0];
                    pages_reg    <= pages_reg + 1'b1;
                    j_reg        <= '0;
                end
                C_NEW_PAGE:
                begin
                    valid_reg[j_reg] <= 1'b1;
                    avail_reg[j_reg] <= 1'b1;
                    top_found_reg    <= 1'b1;
                end
                C_SET_STARTED: started_reg <= 1'b1;
                C_SPLIT_TAIL:
                begin
                    valid_reg[j_reg] <= 1'b1;
                    avail_reg[j_reg] <= 1'b1;
                end
                C_GRANT: avail_reg[best_idx_reg] <= 1'b0;
                default: i_reg <= i_reg;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd)
            C_LOAD:
            begin
                op_reg         <= in_user;
                n_zero_reg     <= (in_data[REQ_W-1:0] == '0);
                need_reg       <= need_in;
                addr_reg       <= in_data[REQ_W+ADDR_W-1:REQ_W];
                res_addr_reg   <= '0;
                res_status_reg <= ST_OK;
            end
            C_A_LOAD:
            begin
                a_start_reg <= rd_start;
                a_len_reg   <= rd_len;
            end
            C_BEST_TAKE:
            begin
                best_idx_reg   <= i_reg;
                best_start_reg <= rd_start;
                best_len_reg   <= rd_len;
            end
            C_TOP_TAKE:
            begin
                top_idx_reg  <= i_reg;
                tb_start_reg <= rd_start;
                tb_len_reg   <= rd_len;
            end
            C_GROW:     old_top_reg <= heap_top_reg;
            C_NEW_PAGE:
            begin
                top_idx_reg  <= j_reg;
                tb_start_reg <= old_top_reg;
                tb_len_reg   <= PAGE_LEN;
            end
            C_EXTEND:   tb_len_reg <= tb_len_ext;
            C_TB_BEST:
            begin
                best_idx_reg   <= top_idx_reg;
                best_start_reg <= tb_start_reg;
                best_len_reg   <= tb_len_reg;
            end
            C_GRANT:
            begin
                res_addr_reg   <= best_start_reg;
                res_status_reg <= ST_OK;
            end
            C_ST_ZERO:     res_status_reg <= ST_ZERO;
            C_ST_NO_ROOM:  res_status_reg <= ST_NO_ROOM;
            C_ST_BAD_FREE: res_status_reg <= ST_BAD_FREE;
            C_OUT:
            begin
                m_addr_reg   <= res_addr_reg;
                m_status_reg <= res_status_reg;
            end
            default: old_top_reg <= old_top_reg;
        endcase
    end

    assign out_valid = m_valid_reg;
    assign out_data  = {{(OUT_DATA_W - ADDR_W - STATUS_W){1'b0}}, m_status_reg, m_addr_reg};

    // a merge retires exactly one descriptor
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == C_MERGE_AJ || cmd == C_MERGE_JA)
        |=> ($countones(valid_reg) == $past($countones(valid_reg)) - 1))
        else $error("merge did not retire one descriptor");
    // a started heap always holds a descriptor
    assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |-> (valid_reg != '0))
        else $error("started heap with empty table");
    // the granted block is a free descriptor
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == C_GRANT) |-> (valid_reg[best_idx_reg] && avail_reg[best_idx_reg]))
        else $error("grant of a block that is not free");
    // the tracked top block ends at the heap top when growing
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == C_GROW && top_found_reg) |-> (tb_end == {1'b0, heap_top_reg}))
        else $error("top block does not end at heap top");

endmodule

>>> design/heap_block_allocator.sv
// A word rejected at decode goes straight to the result; otherwise a sequence of table scans
// runs, each stepping past unused descriptors and reading the examined ones.
// A merge pass visits ordered pairs of free descriptors and restarts after every merge;
// each grown page adds a slot scan over up to 128 descriptors.
// Throughput: one word at a time, the next is taken only after the result is issued.
// Reset: descriptor flags and heap registers clear at once, no clearing pass.
// ----------------------------------------------------------------------------
// heap_block_allocator
// First-fit heap block allocator with coalescing of free neighbors.
// ----------------------------------------------------------------------------
module heap_block_allocator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [hba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hba_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // request_bytes [31:0], block_address [70:32], zero [71]
    input  logic [hba_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // operation [0]
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // granted_address [38:0], status [40:39], zero [47:41]
    output logic [hba_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import hba_pkg::*;

    cmd_t       cmd;
    dp_status_t st;

    hba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    hba_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_user   (s_axis_tuser),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule
